>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/dftm_pkg.sv
// Types and constants shared by the fingerprint table modules.
package dftm_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_INSERT,
        MODE_QUERY
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MREQ,
        S_MCHK,
        S_OREQ,
        S_OCHK,
        S_VREQ,
        S_VCHK
    } t_state;

    // request function codes
    localparam logic [2:0] FN_INS_HDR = 3'd0;
    localparam logic [2:0] FN_INS_OPT = 3'd1;
    localparam logic [2:0] FN_INS_VEN = 3'd2;
    localparam logic [2:0] FN_KEY_HDR = 3'd3;
    localparam logic [2:0] FN_KEY_OPT = 3'd4;
    localparam logic [2:0] FN_KEY_VEN = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOMATCH = 3'd1;
    localparam logic [2:0] ST_TOOLONG = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NOTDHCP = 3'd4;

    // result kinds
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_ANS = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic search_init;
        logic meta_latch;
        logic e_next;
        logic j_clr;
        logic j_next;
        logic emit_miss;
        logic emit_hit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ins_done;
        logic qry_done;
        logic key_bad;
        logic e_end;
        logic meta_ok;
        logic opt_eq;
        logic ven_eq;
        logic j_last_opt;
        logic j_last_ven;
        logic need_ven;
    } t_stat;

endpackage

>>> rtl/dftm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dftm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dftm_ctrl.sv
// Controller: request acceptance, table search sequencing, result valid.
module dftm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  dftm_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output dftm_pkg::t_cmd o_cmd
);
    import dftm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   in_ready;

    assign in_ready = (r_state == S_IDLE) && (!r_out_vld || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.qry_done) n_state = S_MREQ;
            end
            S_MREQ: begin
                if (i_stat.key_bad || i_stat.e_end) n_state = S_IDLE;
                else n_state = S_MCHK;
            end
            S_MCHK: begin
                if (i_stat.meta_ok) n_state = S_OREQ;
                else n_state = S_MREQ;
            end
            S_OREQ: n_state = S_OCHK;
            S_OCHK: begin
                priority if (!i_stat.opt_eq) n_state = S_MREQ;
                else if (i_stat.j_last_opt) n_state = i_stat.need_ven ? S_VREQ : S_IDLE;
                else n_state = S_OREQ;
            end
            S_VREQ: n_state = S_VCHK;
            S_VCHK: begin
                priority if (!i_stat.ven_eq) n_state = S_MREQ;
                else if (i_stat.j_last_ven) n_state = S_IDLE;
                else n_state = S_VREQ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.accept = i_in_valid && in_ready;
        unique case (r_state)
            S_IDLE: o_cmd.search_init = i_stat.qry_done;
            S_MREQ: o_cmd.emit_miss = i_stat.key_bad || i_stat.e_end;
            S_MCHK: begin
                o_cmd.meta_latch = 1'b1;
                o_cmd.j_clr      = i_stat.meta_ok;
                o_cmd.e_next     = !i_stat.meta_ok;
            end
            S_OREQ, S_VREQ: ;
            S_OCHK: begin
                priority if (!i_stat.opt_eq) o_cmd.e_next = 1'b1;
                else if (i_stat.j_last_opt) begin
                    o_cmd.j_clr    = i_stat.need_ven;
                    o_cmd.emit_hit = !i_stat.need_ven;
                end else o_cmd.j_next = 1'b1;
            end
            S_VCHK: begin
                priority if (!i_stat.ven_eq) o_cmd.e_next = 1'b1;
                else if (i_stat.j_last_ven) o_cmd.emit_hit = 1'b1;
                else o_cmd.j_next = 1'b1;
            end
            default: ;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_vld = r_out_vld;
        if (i_out_ready) n_out_vld = 1'b0;
        if (i_stat.ins_done || o_cmd.emit_miss || o_cmd.emit_hit) n_out_vld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_vld;

endmodule

>>> rtl/dftm_dp.sv
// Datapath: load registers, table and key memories, compare logic, result payload.
module dftm_dp #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_OPTIONS = 64,
    parameter int MAX_VENDOR  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dftm_pkg::t_cmd  i_cmd,
    input  logic [2:0]      i_func,
    input  logic [31:0]     i_fp_id,
    input  logic            i_is_dhcp,
    input  logic [7:0]      i_opt_count,
    input  logic            i_vendor_present,
    input  logic [7:0]      i_vendor_len,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last,
    output dftm_pkg::t_stat o_stat,
    output logic            o_kind,
    output logic [2:0]      o_status,
    output logic [5:0]      o_entry_index,
    output logic [31:0]     o_match_id
);
    import dftm_pkg::*;

    localparam int ECW   = $clog2(MAX_ENTRIES + 1);
    localparam int EAW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OLW   = $clog2(MAX_OPTIONS + 1);
    localparam int VLW   = $clog2(MAX_VENDOR + 1);
    localparam int JW    = (OLW > VLW) ? OLW : VLW;
    localparam int KOAW  = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
    localparam int KVAW  = (MAX_VENDOR > 1) ? $clog2(MAX_VENDOR) : 1;
    localparam int ODEP  = MAX_ENTRIES * MAX_OPTIONS;
    localparam int VDEP  = MAX_ENTRIES * MAX_VENDOR;
    localparam int OAW   = (ODEP > 1) ? $clog2(ODEP) : 1;
    localparam int VAW   = (VDEP > 1) ? $clog2(VDEP) : 1;
    localparam int MW    = 32 + OLW + VLW;

    // load state
    t_mode           r_mode, n_mode;
    logic [31:0]     r_pend_id, n_pend_id;
    logic [2:0]      r_pend_status, n_pend_status;
    logic [7:0]      r_decl_opt, n_decl_opt;
    logic [7:0]      r_decl_ven, n_decl_ven;
    logic            r_kvp, n_kvp;
    logic [OLW-1:0]  r_lc, n_lc;
    logic [VLW-1:0]  r_vc, n_vc;
    logic [ECW-1:0]  r_entry_count;

    // search state
    logic [ECW-1:0]  r_e;
    logic [JW-1:0]   r_j;
    logic [31:0]     r_mid;
    logic [VLW-1:0]  r_vlen;
    logic            r_need_ven;

    // result payload
    logic            r_kind;
    logic [2:0]      r_status;
    logic [5:0]      r_idx;
    logic [31:0]     r_id;

    logic opt_we, ven_we, kopt_we, kven_we, meta_we;
    logic ins_done, qry_done;

    logic [MW-1:0]   meta_rdata;
    logic [7:0]      opt_rdata, ven_rdata, kopt_rdata, kven_rdata;
    logic [31:0]     m_id;
    logic [OLW-1:0]  m_olen;
    logic [VLW-1:0]  m_vlen;
    logic            m_need_ven;

    // item decode and load register updates
    always_comb begin
        n_mode        = r_mode;
        n_pend_id     = r_pend_id;
        n_pend_status = r_pend_status;
        n_decl_opt    = r_decl_opt;
        n_decl_ven    = r_decl_ven;
        n_kvp         = r_kvp;
        n_lc          = r_lc;
        n_vc          = r_vc;
        opt_we        = 1'b0;
        ven_we        = 1'b0;
        kopt_we       = 1'b0;
        kven_we       = 1'b0;
        ins_done      = 1'b0;
        qry_done      = 1'b0;
        if (i_cmd.accept) begin
            unique case (i_func)
                FN_INS_HDR: begin
                    n_mode     = MODE_INSERT;
                    n_pend_id  = i_fp_id;
                    n_decl_opt = i_opt_count;
                    n_decl_ven = i_vendor_len;
                    n_lc       = '0;
                    n_vc       = '0;
                    priority if (!i_is_dhcp) n_pend_status = ST_NOTDHCP;
                    else if (i_opt_count > 8'(MAX_OPTIONS) || i_vendor_len > 8'(MAX_VENDOR))
                        n_pend_status = ST_TOOLONG;
                    else if (r_entry_count >= ECW'(MAX_ENTRIES)) n_pend_status = ST_FULL;
                    else n_pend_status = ST_OK;
                    ins_done = i_last;
                end
                FN_INS_OPT: begin
                    if (r_mode == MODE_INSERT) begin
                        if (r_pend_status == ST_OK && 8'(r_lc) < r_decl_opt
                            && r_lc < OLW'(MAX_OPTIONS)) begin
                            opt_we = 1'b1;
                            n_lc   = r_lc + OLW'(1);
                        end
                        ins_done = i_last;
                    end
                end
                FN_INS_VEN: begin
                    if (r_mode == MODE_INSERT) begin
                        if (r_pend_status == ST_OK && 8'(r_vc) < r_decl_ven
                            && r_vc < VLW'(MAX_VENDOR)) begin
                            ven_we = 1'b1;
                            n_vc   = r_vc + VLW'(1);
                        end
                        ins_done = i_last;
                    end
                end
                FN_KEY_HDR: begin
                    n_mode     = MODE_QUERY;
                    n_decl_opt = i_opt_count;
                    n_decl_ven = i_vendor_len;
                    n_kvp      = i_vendor_present;
                    n_lc       = '0;
                    n_vc       = '0;
                    qry_done   = i_last;
                end
                FN_KEY_OPT: begin
                    if (r_mode == MODE_QUERY) begin
                        if (8'(r_lc) < r_decl_opt && r_lc < OLW'(MAX_OPTIONS)) begin
                            kopt_we = 1'b1;
                            n_lc    = r_lc + OLW'(1);
                        end
                        qry_done = i_last;
                    end
                end
                FN_KEY_VEN: begin
                    if (r_mode == MODE_QUERY) begin
                        if (8'(r_vc) < r_decl_ven && r_vc < VLW'(MAX_VENDOR)) begin
                            kven_we = 1'b1;
                            n_vc    = r_vc + VLW'(1);
                        end
                        qry_done = i_last;
                    end
                end
                default: ;
            endcase
        end
        if (ins_done || qry_done) n_mode = MODE_IDLE;
    end

    assign meta_we = ins_done && (n_pend_status == ST_OK);

    // table and key memories
    dftm_ram #(.WIDTH(MW), .DEPTH(MAX_ENTRIES)) u_meta (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(EAW'(r_entry_count)),
        .i_wdata({n_pend_id, n_lc, n_vc}),
        .i_raddr(EAW'(r_e)),
        .o_rdata(meta_rdata)
    );

    dftm_ram #(.WIDTH(8), .DEPTH(ODEP)) u_opt (
        .i_clk  (i_clk),
        .i_we   (opt_we),
        .i_waddr(OAW'(r_entry_count) * OAW'(MAX_OPTIONS) + OAW'(r_lc)),
        .i_wdata(i_data_byte),
        .i_raddr(OAW'(r_e) * OAW'(MAX_OPTIONS) + OAW'(r_j)),
        .o_rdata(opt_rdata)
    );

    dftm_ram #(.WIDTH(8), .DEPTH(VDEP)) u_ven (
        .i_clk  (i_clk),
        .i_we   (ven_we),
        .i_waddr(VAW'(r_entry_count) * VAW'(MAX_VENDOR) + VAW'(r_vc)),
        .i_wdata(i_data_byte),
        .i_raddr(VAW'(r_e) * VAW'(MAX_VENDOR) + VAW'(r_j)),
        .o_rdata(ven_rdata)
    );

    dftm_ram #(.WIDTH(8), .DEPTH(MAX_OPTIONS)) u_kopt (
        .i_clk  (i_clk),
        .i_we   (kopt_we),
        .i_waddr(KOAW'(r_lc)),
        .i_wdata(i_data_byte),
        .i_raddr(KOAW'(r_j)),
        .o_rdata(kopt_rdata)
    );

    dftm_ram #(.WIDTH(8), .DEPTH(MAX_VENDOR)) u_kven (
        .i_clk  (i_clk),
        .i_we   (kven_we),
        .i_waddr(KVAW'(r_vc)),
        .i_wdata(i_data_byte),
        .i_raddr(KVAW'(r_j)),
        .o_rdata(kven_rdata)
    );

    // entry header check against the key
    assign {m_id, m_olen, m_vlen} = meta_rdata;
    assign m_need_ven = r_kvp && (m_vlen != '0);

    always_comb begin
        o_stat            = '0;
        o_stat.ins_done   = ins_done;
        o_stat.qry_done   = qry_done;
        o_stat.key_bad    = (r_lc == '0) || (r_decl_opt > 8'(MAX_OPTIONS));
        o_stat.e_end      = r_e >= r_entry_count;
        o_stat.meta_ok    = (m_olen == r_lc) &&
                            (m_need_ven ? (r_decl_ven <= 8'(MAX_VENDOR) && m_vlen == r_vc)
                                        : (m_vlen == '0));
        o_stat.opt_eq     = opt_rdata == kopt_rdata;
        o_stat.ven_eq     = ven_rdata == kven_rdata;
        o_stat.j_last_opt = (r_j + JW'(1)) == JW'(r_lc);
        o_stat.j_last_ven = (r_j + JW'(1)) == JW'(r_vlen);
        o_stat.need_ven   = r_need_ven;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_pend_status <= ST_OK;
            r_decl_opt    <= '0;
            r_decl_ven    <= '0;
            r_kvp         <= 1'b0;
            r_lc          <= '0;
            r_vc          <= '0;
            r_entry_count <= '0;
            r_e           <= '0;
            r_j           <= '0;
        end else begin
            r_mode        <= n_mode;
            r_pend_status <= n_pend_status;
            r_decl_opt    <= n_decl_opt;
            r_decl_ven    <= n_decl_ven;
            r_kvp         <= n_kvp;
            r_lc          <= n_lc;
            r_vc          <= n_vc;
            if (meta_we) r_entry_count <= r_entry_count + ECW'(1);
            if (i_cmd.search_init) r_e <= '0;
            else if (i_cmd.e_next) r_e <= r_e + ECW'(1);
            if (i_cmd.j_clr) r_j <= '0;
            else if (i_cmd.j_next) r_j <= r_j + JW'(1);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        if (i_cmd.meta_latch) begin
            r_mid      <= m_id;
            r_vlen     <= m_vlen;
            r_need_ven <= m_need_ven;
        end
        priority if (ins_done) begin
            r_kind   <= KIND_ACK;
            r_status <= n_pend_status;
            r_idx    <= (n_pend_status == ST_OK) ? 6'(r_entry_count) : 6'd0;
            r_id     <= '0;
        end else if (i_cmd.emit_miss) begin
            r_kind   <= KIND_ANS;
            r_status <= ST_NOMATCH;
            r_idx    <= '0;
            r_id     <= '0;
        end else if (i_cmd.emit_hit) begin
            r_kind   <= KIND_ANS;
            r_status <= ST_OK;
            r_idx    <= 6'(r_e);
            r_id     <= r_mid;
        end
    end

    assign o_kind        = r_kind;
    assign o_status      = r_status;
    assign o_entry_index = r_idx;
    assign o_match_id    = r_id;

endmodule

>>> rtl/dhcp_fingerprint_table_match_core.sv
// Top level of the DHCP fingerprint table with first-match lookup.
// A request is taken whenever the core is ready; an insert acknowledge is presented the
// cycle after its last request. A query's last request starts a search run by
// the controller over the table memories: for each entry a read of its header
// (id, list lengths), then a read and compare of each option byte and of each
// compared vendor byte, one byte at a time; requests are held off while it runs.
// The single read port of each table memory sets that pace.
// The result register lets the next request in while a result waits, as long
// as the result is taken in the same cycle or the slot is empty.
module dhcp_fingerprint_table_match_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_OPTIONS = 64,
    parameter int MAX_VENDOR  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_fp_id,
    input  logic        i_is_dhcp,
    input  logic [7:0]  i_opt_count,
    input  logic        i_vendor_present,
    input  logic [7:0]  i_vendor_len,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic [31:0] o_match_id
);
    import dftm_pkg::*;
    `include "assert_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    dftm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (cmd)
    );

    dftm_dp #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .MAX_OPTIONS(MAX_OPTIONS),
        .MAX_VENDOR (MAX_VENDOR)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_func),
        .i_fp_id         (i_fp_id),
        .i_is_dhcp       (i_is_dhcp),
        .i_opt_count     (i_opt_count),
        .i_vendor_present(i_vendor_present),
        .i_vendor_len    (i_vendor_len),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .o_stat          (stat),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .o_match_id      (o_match_id)
    );

    // requests only enter when the result slot is free or draining
    `AST_IMPL(a_ready_slot, i_clk, i_rst_n, o_in_ready, !o_out_valid || i_out_ready)
    // an acknowledge never reports a lookup miss
    `AST_IMPL(a_ack_status, i_clk, i_rst_n, o_out_valid && o_kind == KIND_ACK, o_status != ST_NOMATCH)
    // failed results carry no slot and no id
    `AST_IMPL(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_entry_index == 6'd0 && o_match_id == 32'd0)
    // a search start blocks requests on the next cycle
    `AST_NEXT(a_search_busy, i_clk, i_rst_n, cmd.search_init, !o_in_ready)

endmodule

>>> tb/sv/dhcp_fingerprint_table_match_core_tb.sv
// Self-checking testbench for the DHCP fingerprint table match core.
module dhcp_fingerprint_table_match_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dftm_pkg::*;

    localparam int N_ENT = 64;
    localparam int N_OPT = 64;
    localparam int N_VEN = 64;
    // worst case: every request a query walking the whole table, plus stalls
    localparam int CYCLE_LIMIT = 100000000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] fp_id;
        logic        is_dhcp;
        logic [7:0]  opt_count;
        logic        vendor_present;
        logic [7:0]  vendor_len;
        logic [7:0]  data_byte;
        logic        last;
    } t_req;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [31:0] match_id;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_func;
    logic [31:0] i_fp_id;
    logic        i_is_dhcp;
    logic [7:0]  i_opt_count;
    logic        i_vendor_present;
    logic [7:0]  i_vendor_len;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [2:0]  o_status;
    logic [5:0]  o_entry_index;
    logic [31:0] o_match_id;

    dhcp_fingerprint_table_match_core i_dut (.*);

    // predictor state
    int          tbl_count;
    logic [7:0]  tbl_opt [N_ENT][N_OPT];
    int          tbl_opt_len [N_ENT];
    logic [7:0]  tbl_ven [N_ENT][N_VEN];
    int          tbl_ven_len [N_ENT];
    logic [31:0] tbl_id [N_ENT];
    logic [7:0]  key_opt [N_OPT];
    logic [7:0]  key_ven [N_VEN];
    t_mode       ld_mode;
    logic [31:0] ld_id;
    logic [2:0]  ld_status;
    int          ld_decl_opt;
    int          ld_decl_ven;
    logic        ld_key_ven;
    int          ld_opt_cur;
    int          ld_ven_cur;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   n_fail;
    int   n_sent;
    int   cycle_cnt;
    bit   idle_enable;
    bit   hold_sink;
    bit   stim_done;
    int   src_gap;
    int   sink_gap;

    // commit the insert in progress
    function automatic t_res close_insert();
        t_res r;
        r = '0;
        r.kind = KIND_ACK;
        ld_mode = MODE_IDLE;
        r.status = ld_status;
        if (ld_status == ST_OK) begin
            tbl_id[tbl_count] = ld_id;
            tbl_opt_len[tbl_count] = ld_opt_cur;
            tbl_ven_len[tbl_count] = ld_ven_cur;
            r.entry_index = tbl_count[5:0];
            tbl_count++;
        end
        return r;
    endfunction

    // first-match search over the table
    function automatic t_res close_query();
        t_res r;
        bit   hit;
        r = '0;
        r.kind = KIND_ANS;
        r.status = ST_NOMATCH;
        ld_mode = MODE_IDLE;
        if (ld_opt_cur == 0 || ld_decl_opt > N_OPT) return r;
        for (int e = 0; e < tbl_count; e++) begin
            hit = (tbl_opt_len[e] == ld_opt_cur);
            for (int k = 0; hit && k < ld_opt_cur; k++)
                if (tbl_opt[e][k] !== key_opt[k]) hit = 0;
            if (hit) begin
                if (ld_key_ven && tbl_ven_len[e] != 0) begin
                    if (ld_decl_ven > N_VEN || tbl_ven_len[e] != ld_ven_cur) hit = 0;
                    for (int k = 0; hit && k < ld_ven_cur; k++)
                        if (tbl_ven[e][k] !== key_ven[k]) hit = 0;
                end else begin
                    hit = (tbl_ven_len[e] == 0);
                end
            end
            if (hit) begin
                r.status = ST_OK;
                r.entry_index = e[5:0];
                r.match_id = tbl_id[e];
                return r;
            end
        end
        return r;
    endfunction

    // advance the predictor by one accepted request
    function automatic void predict_table(t_req q);
        case (q.func)
            FN_INS_HDR: begin
                ld_mode = MODE_INSERT;
                ld_id = q.fp_id;
                ld_decl_opt = int'(q.opt_count);
                ld_decl_ven = int'(q.vendor_len);
                ld_opt_cur = 0;
                ld_ven_cur = 0;
                if (!q.is_dhcp) ld_status = ST_NOTDHCP;
                else if (ld_decl_opt > N_OPT || ld_decl_ven > N_VEN) ld_status = ST_TOOLONG;
                else if (tbl_count >= N_ENT) ld_status = ST_FULL;
                else ld_status = ST_OK;
                if (q.last) expected_results.push_back(close_insert());
            end
            FN_INS_OPT, FN_INS_VEN: begin
                if (ld_mode == MODE_INSERT) begin
                    if (ld_status == ST_OK) begin
                        if (q.func == FN_INS_OPT) begin
                            if (ld_opt_cur < ld_decl_opt && ld_opt_cur < N_OPT) begin
                                tbl_opt[tbl_count][ld_opt_cur] = q.data_byte;
                                ld_opt_cur++;
                            end
                        end else if (ld_ven_cur < ld_decl_ven && ld_ven_cur < N_VEN) begin
                            tbl_ven[tbl_count][ld_ven_cur] = q.data_byte;
                            ld_ven_cur++;
                        end
                    end
                    if (q.last) expected_results.push_back(close_insert());
                end
            end
            FN_KEY_HDR: begin
                ld_mode = MODE_QUERY;
                ld_decl_opt = int'(q.opt_count);
                ld_decl_ven = int'(q.vendor_len);
                ld_key_ven = q.vendor_present;
                ld_opt_cur = 0;
                ld_ven_cur = 0;
                if (q.last) expected_results.push_back(close_query());
            end
            FN_KEY_OPT, FN_KEY_VEN: begin
                if (ld_mode == MODE_QUERY) begin
                    if (q.func == FN_KEY_OPT) begin
                        if (ld_opt_cur < ld_decl_opt && ld_opt_cur < N_OPT) begin
                            key_opt[ld_opt_cur] = q.data_byte;
                            ld_opt_cur++;
                        end
                    end else if (ld_ven_cur < ld_decl_ven && ld_ven_cur < N_VEN) begin
                        key_ven[ld_ven_cur] = q.data_byte;
                        ld_ven_cur++;
                    end
                    if (q.last) expected_results.push_back(close_query());
                end
            end
            default: ;
        endcase
    endfunction

    // random request with noisy data fields, is_dhcp set and last clear
    function automatic t_req rand_req(logic [2:0] fn);
        t_req q;
        q.func = fn;
        q.fp_id = $urandom;
        q.is_dhcp = 1'b1;
        q.opt_count = 8'($urandom);
        q.vendor_present = 1'($urandom);
        q.vendor_len = 8'($urandom);
        q.data_byte = 8'($urandom);
        q.last = 1'b0;
        return q;
    endfunction

    // queue one insert or query made of header plus byte lists
    task automatic queue_load(bit is_key, logic [31:0] id, bit dhcp, bit vp,
                              int n_opt, int n_ven, int decl_opt, int decl_ven,
                              logic [7:0] opts[$], logic [7:0] vens[$]);
        t_req q;
        int   total;
        total = n_opt + n_ven;
        q = rand_req(is_key ? FN_KEY_HDR : FN_INS_HDR);
        q.fp_id = id;
        q.is_dhcp = dhcp;
        q.vendor_present = vp;
        q.opt_count = 8'(decl_opt);
        q.vendor_len = 8'(decl_ven);
        q.last = (total == 0);
        pending_reqs.push_back(q);
        for (int k = 0; k < total; k++) begin
            q = rand_req(k < n_opt ? (is_key ? FN_KEY_OPT : FN_INS_OPT)
                                   : (is_key ? FN_KEY_VEN : FN_INS_VEN));
            q.data_byte = (k < n_opt) ? opts[k % opts.size()] : vens[(k - n_opt) % vens.size()];
            q.last = (k == total - 1);
            pending_reqs.push_back(q);
        end
    endtask

    // fingerprints reused by inserts and queries so lookups hit
    logic [7:0] fp_opts [8][$];
    logic [7:0] fp_vens [8][$];

    task automatic queue_known(bit is_key, int f, bit vp, bit full_vendor);
        int no;
        int nv;
        no = fp_opts[f].size();
        nv = full_vendor ? fp_vens[f].size() : 0;
        queue_load(is_key, $urandom, 1'b1, vp, no, nv, no, nv, fp_opts[f], fp_vens[f]);
    endtask

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus
    initial begin
        logic [7:0] ones[$];
        logic [7:0] zeros[$];
        int         sel;
        int         n;
        tbl_count = 0;
        ld_mode = MODE_IDLE;
        ld_status = ST_OK;
        ld_key_ven = 0;
        ld_opt_cur = 0;
        ld_ven_cur = 0;
        ld_decl_opt = 0;
        ld_decl_ven = 0;
        n_fail = 0;
        idle_enable = 1;
        hold_sink = 0;
        stim_done = 0;
        ones = '{8'hff};
        zeros = '{8'h00};
        for (int f = 0; f < 8; f++) begin
            n = (f == 0) ? N_OPT : $urandom_range(1, 6);
            for (int k = 0; k < n; k++) fp_opts[f].push_back(8'($urandom));
            n = (f == 1) ? N_VEN : ((f % 2) ? $urandom_range(1, 5) : 0);
            for (int k = 0; k < n; k++) fp_vens[f].push_back(8'($urandom));
            if (fp_vens[f].size() == 0) fp_vens[f].push_back(8'h00);
        end

        // directed: status cases, empty list, extremes, stray and unused codes
        queue_load(0, 32'hffffffff, 0, 0, 1, 0, 1, 0, ones, zeros);
        queue_load(0, 32'h1, 1, 0, 0, 0, N_OPT + 1, 0, ones, zeros);
        queue_load(0, 32'h2, 1, 0, 0, 1, 1, 255, ones, zeros);
        queue_load(0, 32'h0, 1, 0, 0, 0, 0, 0, ones, zeros);
        queue_load(0, 32'hffffffff, 1, 0, 2, 0, 2, 0, ones, zeros);
        queue_load(0, 32'h5a5a5a5a, 1, 0, 3, 2, 2, 1, zeros, ones);
        queue_known(0, 0, 0, 1);
        queue_known(0, 1, 0, 1);
        queue_load(1, 0, 1, 0, 2, 0, 2, 0, ones, zeros);
        queue_load(1, 0, 1, 1, 2, 1, 2, 1, zeros, ones);
        queue_load(1, 0, 1, 1, 0, 0, 0, 0, ones, zeros);
        queue_load(1, 0, 1, 0, 1, 0, 255, 0, ones, zeros);
        queue_load(1, 0, 1, 1, 2, 3, 2, 255, ones, ones);
        queue_known(1, 1, 1, 1);
        queue_known(1, 0, 1, 1);
        begin
            t_req q;
            q = rand_req(FN_INS_OPT); q.last = 1; pending_reqs.push_back(q);
            q = rand_req(FN_KEY_VEN); q.last = 1; pending_reqs.push_back(q);
            q = rand_req(3'd6); q.last = 1; pending_reqs.push_back(q);
            q = rand_req(3'd7); q.last = 1; pending_reqs.push_back(q);
            q = rand_req(FN_INS_HDR); q.opt_count = 2; q.vendor_len = 0;
            pending_reqs.push_back(q);
            q = rand_req(FN_KEY_HDR); q.last = 1; pending_reqs.push_back(q);
        end

        // random: mostly well-formed loads from known fingerprints
        while (pending_reqs.size() < 1400) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                queue_known(0, $urandom_range(0, 7), 0, 1'($urandom_range(0, 1)));
            end else if (sel < 70) begin
                queue_known(1, $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 3) != 0);
            end else if (sel < 85) begin
                n = $urandom_range(0, 4);
                queue_load(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 7) != 0,
                           1'($urandom), n, $urandom_range(0, 3), $urandom_range(0, 6),
                           $urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 4),
                           fp_opts[$urandom_range(0, 7)], fp_vens[$urandom_range(0, 7)]);
            end else begin
                t_req q;
                q = rand_req(3'($urandom_range(0, 7)));
                q.is_dhcp = 1'($urandom);
                q.last = 1'($urandom);
                pending_reqs.push_back(q);
            end
            // long sink stall while requests keep coming
            if (pending_reqs.size() > 700 && pending_reqs.size() < 760) hold_sink = 1;
        end
        stim_done = 1;
    end

    // sink hold-off in its own process
    initial begin
        wait (hold_sink);
        repeat (400) @(posedge i_clk);
        hold_sink = 0;
    end

    // driver
    int  drain_point;
    bit  drained;
    initial begin
        drain_point = 600;
        drained = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            {i_func, i_fp_id, i_is_dhcp, i_opt_count, i_vendor_present,
             i_vendor_len, i_data_byte, i_last} <= '0;
            src_gap <= 0;
            n_sent <= 0;
        end else begin
            automatic bit fire = i_in_valid && o_in_ready;
            automatic int sent = n_sent + int'(fire);
            if (fire) begin
                predict_table({i_func, i_fp_id, i_is_dhcp, i_opt_count,
                               i_vendor_present, i_vendor_len, i_data_byte, i_last});
                n_sent <= sent;
            end
            if (i_in_valid && !fire) begin
                // hold the request
            end else if (src_gap > 0) begin
                i_in_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (sent == drain_point && !drained && expected_results.size() != 0) begin
                // pause the source until all results are back
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && stim_done) begin
                automatic t_req q = pending_reqs.pop_front();
                if (sent == drain_point) drained <= 1;
                i_in_valid <= 1'b1;
                {i_func, i_fp_id, i_is_dhcp, i_opt_count, i_vendor_present,
                 i_vendor_len, i_data_byte, i_last} <= q;
                if (idle_enable && pending_reqs.size() > 150 && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 18);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and sink backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                automatic t_res got = {o_kind, o_status, o_entry_index, o_match_id};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    n_fail++;
                end else begin
                    automatic t_res exp_r = expected_results.pop_front();
                    if (got.kind !== exp_r.kind) begin
                        $display("%0t: kind exp %0d got %0d", $realtime, exp_r.kind, got.kind);
                        n_fail++;
                    end
                    if (got.status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $realtime,
                                 exp_r.status, got.status);
                        n_fail++;
                    end
                    if (got.entry_index !== exp_r.entry_index) begin
                        $display("%0t: entry_index exp %0d got %0d", $realtime,
                                 exp_r.entry_index, got.entry_index);
                        n_fail++;
                    end
                    if (got.match_id !== exp_r.match_id) begin
                        $display("%0t: match_id exp %h got %h", $realtime,
                                 exp_r.match_id, got.match_id);
                        n_fail++;
                    end
                end
            end
            if (hold_sink) begin
                i_out_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                i_out_ready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (idle_enable && pending_reqs.size() > 150 && $urandom_range(0, 9) == 0)
                    sink_gap <= $urandom_range(1, 18);
            end
        end
    end

    // end of run and watchdog
    initial begin
        cycle_cnt = 0;
        wait (stim_done);
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("dhcp_fingerprint_table_match_core regression: fail");
                $finish;
            end
        end
        repeat (100) @(posedge i_clk);
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("dhcp_fingerprint_table_match_core regression: pass");
        end else begin
            $display("dhcp_fingerprint_table_match_core regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dftm_pkg.sv
rtl/dftm_ram.sv
rtl/dftm_ctrl.sv
rtl/dftm_dp.sv
rtl/dhcp_fingerprint_table_match_core.sv
tb/sv/dhcp_fingerprint_table_match_core_tb.sv
